/* sv/bfa_pkg.sv */
// shared types, request and status codes, and helpers for the bitmap frame allocator
// no dependencies

package bfa_pkg;

	localparam int NUM_FRAMES_DEF      = 4096;
	localparam int RESERVED_FRAMES_DEF = 1024;
	localparam int PAGE_BYTES_DEF      = 4096;

	localparam int FRAME_LIMIT_W = 13;
	localparam logic [FRAME_LIMIT_W-1:0] FRAME_LIMIT_RST = 13'd4096;

	// configuration space: word index taken from paddr[2]
	localparam int PADDR_W = 3;
	localparam logic REG_FRAME_LIMIT = 1'b0;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_MARK  = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OOM   = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] phys_address;
	} bfa_req_t;

	typedef struct packed {
		logic [31:0] frame_address;
		logic        frame_free;
		logic [1:0]  status;
	} bfa_rsp_t;

	// outcome of checking one bitmap word during an allocate scan
	typedef struct packed {
		logic       found;
		logic [4:0] pos;
		logic       last;
	} bfa_scan_t;

	// bits of the 32-frame word starting at frame base whose frame lies below lim
	function automatic logic [31:0] low_mask(input logic [31:0] base, input logic [31:0] lim);
		logic [31:0] diff;
		diff = lim - base;
		if (lim <= base) begin
			return '0;
		end else if (diff >= 32'd32) begin
			return '1;
		end else begin
			return (32'd1 << diff[4:0]) - 32'd1;
		end
	endfunction

endpackage

/* sv/bfa_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies

module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/bfa_scan.sv */
// checks one bitmap word for the lowest free frame below the frame limit
// depends on bfa_pkg

module bfa_scan #(
	parameter int AW = 7,
	parameter int LW = 13
) (
	input  logic [31:0]          word,
	input  logic [AW-1:0]        word_idx,
	input  logic [LW-1:0]        lim,
	output bfa_pkg::bfa_scan_t   res
);
	import bfa_pkg::*;

	logic [31:0] base;
	logic [31:0] lim32;
	logic [31:0] free_bits;

	assign base      = 32'({word_idx, 5'b0});
	assign lim32     = 32'(lim);
	assign free_bits = ~word & low_mask(base, lim32);

	always_comb begin
		res.pos = '0;
		for (int j = 31; j >= 0; j--) begin
			if (free_bits[j]) begin
				res.pos = 5'(j);
			end
		end
		res.found = |free_bits;
		// no frames of the limit lie beyond this word
		res.last  = (base + 32'd32) >= lim32;
	end

endmodule

/* sv/bfa_cfg.sv */
// APB-style configuration port holding the frame limit register
// depends on bfa_pkg

module bfa_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output logic [bfa_pkg::FRAME_LIMIT_W-1:0]   frame_limit
);
	import bfa_pkg::*;

	logic [FRAME_LIMIT_W-1:0] frame_limit_q;
	logic                     sel_limit;

	assign sel_limit = (paddr[2] == REG_FRAME_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= FRAME_LIMIT_RST;
		end else if (psel && penable && pwrite && sel_limit) begin
			frame_limit_q <= pwdata[FRAME_LIMIT_W-1:0];
		end
	end

	assign pready      = 1'b1;
	assign prdata      = sel_limit ? 32'(frame_limit_q) : '0;
	assign frame_limit = frame_limit_q;

endmodule

/* sv/bitmap_frame_allocator.sv */
// top level of the first-fit bitmap page frame allocator: request sequencer around the bitmap RAM
// depends on bfa_pkg, bfa_ram, bfa_scan and bfa_cfg

// The used bitmap sits in one RAM of 32-bit words, one bit per frame. After reset the block
// writes the reserved-frame pattern into every bitmap word (128 at the default size) in turn
// and takes no request until that pass ends; configuration writes are taken throughout.
// Free, mark and query each read the frame's word, then, once the output register is free,
// do the write-back or give the answer. An allocate reads the bitmap words in turn from word 0
// until one holds a free frame below the limit or no word with such frames is left, since the
// RAM's single read port delivers one word per cycle. One request is in work at a time; the
// next is taken while the last result still waits in the output register.

module bitmap_frame_allocator #(
	parameter int NUM_FRAMES      = bfa_pkg::NUM_FRAMES_DEF,
	parameter int RESERVED_FRAMES = bfa_pkg::RESERVED_FRAMES_DEF,
	parameter int PAGE_BYTES      = bfa_pkg::PAGE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  bfa_pkg::bfa_req_t              req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output bfa_pkg::bfa_rsp_t              rsp
);
	import bfa_pkg::*;

	localparam int WORDS      = (NUM_FRAMES + 31) / 32;
	localparam int AW         = $clog2(WORDS);
	localparam int LW         = $clog2(NUM_FRAMES + 1);
	localparam int FW         = AW + 5;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int RES_CAP    = (RESERVED_FRAMES > NUM_FRAMES) ? NUM_FRAMES : RESERVED_FRAMES;

	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_RMW  = 2'd2;
	localparam logic [1:0] S_SCAN = 2'd3;

	logic [1:0]               state_q;
	logic [AW-1:0]            init_ptr_q;
	logic [AW-1:0]            word_q;
	logic [4:0]               bit_q;
	logic [1:0]               type_q;
	logic                     range_err_q;
	bfa_rsp_t                 rsp_q;
	logic                     rsp_valid_q;

	logic [FRAME_LIMIT_W-1:0] frame_limit;
	logic [LW-1:0]            lim;
	logic [31:0]              idx32;
	logic                     idx_range_err;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [31:0]              ram_wdata;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [31:0]              ram_rdata;

	bfa_scan_t                scan;
	logic [31:0]              bit_mask;
	logic [63:0]              alloc_addr;
	logic                     out_free;
	logic                     accept;
	logic                     rsp_load;
	bfa_rsp_t                 rsp_d;

	bfa_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.frame_limit (frame_limit)
	);

	bfa_ram #(
		.WIDTH (32),
		.DEPTH (WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bfa_scan #(
		.AW (AW),
		.LW (LW)
	) u_scan (
		.word     (ram_rdata),
		.word_idx (word_q),
		.lim      (lim),
		.res      (scan)
	);

	// a limit above the bitmap size acts as the bitmap size
	assign lim = (32'(frame_limit) > 32'(NUM_FRAMES)) ? LW'(NUM_FRAMES) : LW'(frame_limit);

	assign idx32         = req.phys_address >> PAGE_SHIFT;
	assign idx_range_err = idx32 >= 32'(lim);

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign bit_mask   = 32'd1 << bit_q;
	assign alloc_addr = 64'({word_q, scan.pos}) << PAGE_SHIFT;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = idx32[FW-1:5];
		rsp_load  = 1'b0;
		rsp_d     = '0;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_ptr_q;
				ram_wdata = low_mask(32'({init_ptr_q, 5'b0}), 32'(RES_CAP));
			end
			S_IDLE: begin
				ram_re = accept;
				if (req.req_type == REQ_ALLOC) begin
					ram_raddr = '0;
				end
			end
			S_RMW: begin
				if (out_free) begin
					rsp_load = 1'b1;
					if (range_err_q) begin
						rsp_d.status = STAT_RANGE;
					end else begin
						unique case (type_q)
							REQ_FREE: begin
								ram_we    = 1'b1;
								ram_wdata = ram_rdata & ~bit_mask;
							end
							REQ_MARK: begin
								ram_we    = 1'b1;
								ram_wdata = ram_rdata | bit_mask;
							end
							REQ_QUERY: begin
								rsp_d.frame_free = ~ram_rdata[bit_q];
							end
							REQ_ALLOC: begin
							end
						endcase
					end
				end
			end
			S_SCAN: begin
				if (!scan.found && !scan.last) begin
					ram_re    = 1'b1;
					ram_raddr = word_q + AW'(1);
				end else if (out_free) begin
					rsp_load = 1'b1;
					if (scan.found) begin
						ram_we              = 1'b1;
						ram_wdata           = ram_rdata | (32'd1 << scan.pos);
						rsp_d.frame_address = alloc_addr[31:0];
					end else begin
						rsp_d.status = STAT_OOM;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_ptr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					init_ptr_q <= init_ptr_q + AW'(1);
					if (32'(init_ptr_q) == 32'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= (req.req_type == REQ_ALLOC) ? S_SCAN : S_RMW;
					end
				end
				S_RMW: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// request payload, scan position and response register
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q      <= req.req_type;
			range_err_q <= idx_range_err;
			bit_q       <= idx32[4:0];
			word_q      <= (req.req_type == REQ_ALLOC) ? '0 : idx32[FW-1:5];
		end else if (state_q == S_SCAN && ram_re) begin
			word_q <= ram_raddr;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
